/* design/mme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg: shared types and codes of the matrix multiply engine
// Item layouts, command and operand-form codes, register indexes, and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package mme_pkg;

    // index width of one matrix dimension (up to 8)
    localparam int IDX_W = 3;
    localparam int VAL_W = 32;
    localparam int DIM_W = 4;
    localparam int FORM_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    // full product plus growth for up to 8 terms
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W = PROD_W + 3;

    // item commands
    localparam logic [1:0] CMD_WR_A = 2'd0;
    localparam logic [1:0] CMD_WR_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // operand forms
    localparam logic [FORM_W-1:0] FORM_AB = 2'd0;
    localparam logic [FORM_W-1:0] FORM_ATB = 2'd1;
    localparam logic [FORM_W-1:0] FORM_ABT = 2'd2;
    localparam logic [FORM_W-1:0] FORM_ATA = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_FORM = 2'd3;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] product;
        logic                    last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic                    wr_a;
        logic                    wr_b;
        logic [IDX_W-1:0]        wr_row;
        logic [IDX_W-1:0]        wr_col;
        logic signed [VAL_W-1:0] wr_value;
        logic                    issue;
        logic [IDX_W-1:0]        i;
        logic [IDX_W-1:0]        j;
        logic [IDX_W-1:0]        k;
        logic                    first_k;
        logic                    last_k;
        logic                    last_elem;
        logic [FORM_W-1:0]       form;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pipe_empty;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/mme_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_ctrl: controller of the matrix multiply engine
// Holds the size and form registers, accepts items, forwards store writes,
// and walks the (i, j, k) multiply-accumulate sequence of a compute.
// ----------------------------------------------------------------------------
module mme_ctrl
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_item_t              cmd_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output dp_cmd_t                    dp_cmd,
    input  wire dp_stat_t              dp_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [DIM_W-1:0]  out_rows_reg, inner_len_reg, out_cols_reg;
    logic [FORM_W-1:0] form_cfg_reg;
    logic [FORM_W-1:0] form_reg, form_next;
    logic [IDX_W-1:0]  rlim_reg, rlim_next;
    logic [IDX_W-1:0]  klim_reg, klim_next;
    logic [IDX_W-1:0]  clim_reg, clim_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic              accept;
    logic              k_end, j_end, i_end;

    // used dimension minus one: zero reads as one, too large as MAX_DIM
    function automatic logic [IDX_W-1:0] dim_lim(input logic [DIM_W-1:0] d);
        if (d == '0)
        begin
            return '0;
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            return IDX_W'(MAX_DIM - 1);
        end
        return IDX_W'(d - DIM_W'(1));
    endfunction

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign k_end = (k_reg == klim_reg);
    assign j_end = (j_reg == clim_reg);
    assign i_end = (i_reg == rlim_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_rows_reg <= DIM_W'(8);
            inner_len_reg <= DIM_W'(8);
            out_cols_reg <= DIM_W'(8);
            form_cfg_reg <= FORM_AB;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OUT_ROWS:     out_rows_reg <= cfg_data;
                CFG_INNER_LEN:    inner_len_reg <= cfg_data;
                CFG_OUT_COLS:     out_cols_reg <= cfg_data;
                CFG_OPERAND_FORM: form_cfg_reg <= cfg_data[FORM_W-1:0];
                default:          ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        form_next = form_reg;
        rlim_next = rlim_reg;
        klim_next = klim_reg;
        clim_next = clim_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd_item.cmd == CMD_COMPUTE)
                begin
                    state_next = ST_RUN;
                    form_next = form_cfg_reg;
                    rlim_next = dim_lim(out_rows_reg);
                    klim_next = dim_lim(inner_len_reg);
                    clim_next = dim_lim(out_cols_reg);
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                end
            end
            ST_RUN:
            begin
                // k innermost, then column, then row
                if (!k_end)
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                else
                begin
                    k_next = '0;
                    if (!j_end)
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (!i_end)
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (dp_stat.pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            form_reg <= FORM_AB;
            rlim_reg <= '0;
            klim_reg <= '0;
            clim_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            form_reg <= form_next;
            rlim_reg <= rlim_next;
            klim_reg <= klim_next;
            clim_reg <= clim_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
        end
    end

    // commands to the datapath
    always_comb
    begin
        dp_cmd.wr_a = accept && (cmd_item.cmd == CMD_WR_A);
        dp_cmd.wr_b = accept && (cmd_item.cmd == CMD_WR_B);
        dp_cmd.wr_row = cmd_item.row;
        dp_cmd.wr_col = cmd_item.col;
        dp_cmd.wr_value = cmd_item.value;
        dp_cmd.issue = (state_reg == ST_RUN);
        dp_cmd.i = i_reg;
        dp_cmd.j = j_reg;
        dp_cmd.k = k_reg;
        dp_cmd.first_k = (k_reg == '0);
        dp_cmd.last_k = k_end;
        dp_cmd.last_elem = i_end && j_end;
        dp_cmd.form = form_reg;
    end

endmodule

`default_nettype wire

/* design/mme_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mme_datapath: stores and multiply-accumulate pipeline
// A and B stores (A with two read ports), operand read, 32x32 multiply,
// wide accumulate, then shift to fixed point with saturation.
// ----------------------------------------------------------------------------
module mme_datapath
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire dp_cmd_t dp_cmd,
    output dp_stat_t     dp_stat,
    output logic         result_valid,
    output out_item_t    result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SAT_LSB = VAL_W - 1 + FRAC_BITS;

    logic [VAL_W-1:0] a_mem [DEPTH];
    logic [VAL_W-1:0] b_mem [DEPTH];

    logic [AW-1:0] wr_addr, a_addr0, a_addr1, b_addr;
    logic          wr_in_range;

    // stage 1: operand read
    logic [VAL_W-1:0] a_rd0_reg, a_rd1_reg, b_rd_reg;
    logic             v1_reg, first1_reg, lastk1_reg, laste1_reg, sel_a1_reg;
    logic [IDX_W-1:0] i1_reg, j1_reg;
    // stage 2: product
    logic signed [VAL_W-1:0]  op_x, op_y;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic                     v2_reg, first2_reg, lastk2_reg, laste2_reg;
    logic [IDX_W-1:0]         i2_reg, j2_reg;
    // stage 3: accumulate
    logic signed [ACC_W-1:0] acc_next, acc_reg;
    logic                    done3_reg, laste3_reg;
    logic [IDX_W-1:0]        i3_reg, j3_reg;
    // stage 4: result
    logic                        sat_ok;
    logic signed [VAL_W-1:0]     prod_fx;
    out_item_t                   result_next;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
        logic [AW+IDX_W:0] t;
        t = (AW+IDX_W+1)'(r) * (AW+IDX_W+1)'(MAX_DIM) + (AW+IDX_W+1)'(c);
        return t[AW-1:0];
    endfunction

    // address selection by operand form
    always_comb
    begin
        wr_in_range = ({1'b0, dp_cmd.wr_row} < (IDX_W+1)'(MAX_DIM))
                   && ({1'b0, dp_cmd.wr_col} < (IDX_W+1)'(MAX_DIM));
        wr_addr = addr_of(dp_cmd.wr_row, dp_cmd.wr_col);
        a_addr1 = addr_of(dp_cmd.k, dp_cmd.j);
        unique case (dp_cmd.form)
            FORM_AB:
            begin
                a_addr0 = addr_of(dp_cmd.i, dp_cmd.k);
                b_addr = addr_of(dp_cmd.k, dp_cmd.j);
            end
            FORM_ATB:
            begin
                a_addr0 = addr_of(dp_cmd.k, dp_cmd.i);
                b_addr = addr_of(dp_cmd.k, dp_cmd.j);
            end
            FORM_ABT:
            begin
                a_addr0 = addr_of(dp_cmd.i, dp_cmd.k);
                b_addr = addr_of(dp_cmd.j, dp_cmd.k);
            end
            FORM_ATA:
            begin
                a_addr0 = addr_of(dp_cmd.k, dp_cmd.i);
                b_addr = addr_of(dp_cmd.k, dp_cmd.j);
            end
            default:
            begin
                a_addr0 = '0;
                b_addr = '0;
            end
        endcase
    end

    // A store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_a && wr_in_range)
        begin
            a_mem[wr_addr] <= dp_cmd.wr_value;
        end
        a_rd0_reg <= a_mem[a_addr0];
        a_rd1_reg <= a_mem[a_addr1];
    end

    // B store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_b && wr_in_range)
        begin
            b_mem[wr_addr] <= dp_cmd.wr_value;
        end
        b_rd_reg <= b_mem[b_addr];
    end

    // multiply operands; A against A in the At*A form
    assign op_x = a_rd0_reg;
    assign op_y = sel_a1_reg ? a_rd1_reg : b_rd_reg;
    assign prod_next = op_x * op_y;

    // accumulate at full width
    assign acc_next = first2_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    // truncate toward minus infinity, saturate to 32 bits
    always_comb
    begin
        sat_ok = (&acc_reg[ACC_W-1:SAT_LSB]) || !(|acc_reg[ACC_W-1:SAT_LSB]);
        if (sat_ok)
        begin
            prod_fx = acc_reg[SAT_LSB:FRAC_BITS];
        end
        else if (acc_reg[ACC_W-1])
        begin
            prod_fx = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            prod_fx = {1'b0, {(VAL_W-1){1'b1}}};
        end
        result_next.out_row = i3_reg;
        result_next.out_col = j3_reg;
        result_next.product = prod_fx;
        result_next.last = laste3_reg;
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done3_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            v1_reg <= dp_cmd.issue;
            v2_reg <= v1_reg;
            done3_reg <= v2_reg && lastk2_reg;
            result_valid <= done3_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        first1_reg <= dp_cmd.first_k;
        lastk1_reg <= dp_cmd.last_k;
        laste1_reg <= dp_cmd.last_elem;
        sel_a1_reg <= (dp_cmd.form == FORM_ATA);
        i1_reg <= dp_cmd.i;
        j1_reg <= dp_cmd.j;

        prod_reg <= prod_next;
        first2_reg <= first1_reg;
        lastk2_reg <= lastk1_reg;
        laste2_reg <= laste1_reg;
        i2_reg <= i1_reg;
        j2_reg <= j1_reg;

        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        laste3_reg <= laste2_reg;
        i3_reg <= i2_reg;
        j3_reg <= j2_reg;

        if (done3_reg)
        begin
            result <= result_next;
        end
    end

    assign dp_stat.pipe_empty = !v1_reg && !v2_reg && !done3_reg;

endmodule

`default_nettype wire

/* design/matrix_multiply_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine: fixed-point matrix product over two small stores
// Loads A and B entry by entry and streams out the product in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. cmd_item
//   carries the command, row, col and a signed Q16.16 value. Write commands
//   store one entry of A or B and give no result; a load stream runs at one
//   item per cycle while busy stays low. A compute item raises busy and walks
//   rows x cols x inner_len multiply-accumulate steps, one per cycle through
//   a single 32x32 multiplier; busy stays high until the pipeline has drained.
//   Each product element shows on result for exactly one cycle with
//   result_valid high once its inner_len steps have left the pipeline, the
//   final one marked by last. The receiver cannot stall the block; results
//   are never held back.
//   Size and form registers are to be written through cfg_we / cfg_index /
//   cfg_data only while idle (the block does not enforce this) and take
//   effect at the next compute. Reset clears the registers to 8 x 8 x 8,
//   form A*B, and the controller to idle; the stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_item_t              cmd_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       result_valid,
    output out_item_t                  result
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    mme_ctrl #(
        .MAX_DIM(MAX_DIM)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd_item(cmd_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .dp_cmd(dp_cmd),
        .dp_stat(dp_stat)
    );

    mme_datapath #(
        .MAX_DIM(MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .dp_cmd(dp_cmd),
        .dp_stat(dp_stat),
        .result_valid(result_valid),
        .result(result)
    );

    // results only come out of a compute in progress
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a compute");

    // a compute item starts the sequencer
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd_item.cmd == CMD_COMPUTE) |=> busy)
        else $error("compute item not started");

    // the final element is followed by a gap
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result right after final element");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matrix_multiply_engine
// Loads the A and B stores through the command port, sweeps sizes and the four
// operand forms, and checks every streamed product element (row, column,
// saturated Q16.16 value, last flag) against a bit-exact software product
// kept in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    import mme_pkg::*;

    localparam int DIM = 8;
    localparam int FRAC = 16;
    // minimum number of items to send over the run
    localparam int ITEM_TARGET = 130;
    // command code with no effect
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Tracks the stores and size registers, and queues the product elements due
    class product_tracker;
        logic [VAL_W-1:0] a_mat [DIM*DIM];
        logic [VAL_W-1:0] b_mat [DIM*DIM];
        logic [DIM_W-1:0] rows_reg = 4'd8;
        logic [DIM_W-1:0] inner_reg = 4'd8;
        logic [DIM_W-1:0] cols_reg = 4'd8;
        logic [FORM_W-1:0] form_reg = FORM_AB;
        out_item_t elements_due [$];
        int bad_elements = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OUT_ROWS:  rows_reg = data;
                CFG_INNER_LEN: inner_reg = data;
                CFG_OUT_COLS:  cols_reg = data;
                default:       form_reg = data[FORM_W-1:0];
            endcase
        endfunction

        // zero reads as one, above the store size reads as the store size
        function int fit_dim(logic [DIM_W-1:0] d);
            if (d == 0)
                return 1;
            if (d > DIM)
                return DIM;
            return int'(d);
        endfunction

        // exact sum of products, floor shift, then saturate to 32 bits
        function logic [VAL_W-1:0] element_value(int i, int j, int klen);
            logic signed [VAL_W-1:0] x;
            logic signed [VAL_W-1:0] y;
            logic signed [2*VAL_W-1:0] p;
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] q;
            acc = '0;
            for (int k = 0; k < klen; k++)
            begin
                case (form_reg)
                    FORM_AB:
                    begin
                        x = a_mat[i*DIM+k];
                        y = b_mat[k*DIM+j];
                    end
                    FORM_ATB:
                    begin
                        x = a_mat[k*DIM+i];
                        y = b_mat[k*DIM+j];
                    end
                    FORM_ABT:
                    begin
                        x = a_mat[i*DIM+k];
                        y = b_mat[j*DIM+k];
                    end
                    default:
                    begin
                        x = a_mat[k*DIM+i];
                        y = a_mat[k*DIM+j];
                    end
                endcase
                p = x * y;
                acc = acc + p;
            end
            q = acc >>> FRAC;
            if (q[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){q[ACC_W-1]}})
                return acc[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            return q[VAL_W-1:0];
        endfunction

        // note an accepted item: store an entry or queue the whole product
        function void take_item(in_item_t it);
            int nr;
            int nk;
            int nc;
            out_item_t due;
            case (it.cmd)
                CMD_WR_A: a_mat[{it.row, it.col}] = it.value;
                CMD_WR_B: b_mat[{it.row, it.col}] = it.value;
                CMD_COMPUTE:
                begin
                    nr = fit_dim(rows_reg);
                    nk = fit_dim(inner_reg);
                    nc = fit_dim(cols_reg);
                    for (int i = 0; i < nr; i++)
                        for (int j = 0; j < nc; j++)
                        begin
                            due.out_row = IDX_W'(i);
                            due.out_col = IDX_W'(j);
                            due.product = element_value(i, j, nk);
                            due.last = (i == nr - 1) && (j == nc - 1);
                            elements_due.push_back(due);
                        end
                end
                default: ;
            endcase
        endfunction

        // compare one streamed element with the oldest one due
        function void match_element(out_item_t got);
            out_item_t want;
            if (elements_due.size() == 0)
            begin
                bad_elements++;
                if (bad_elements <= 10)
                    $display("unexpected element: row %0d col %0d product %h last %0b",
                             got.out_row, got.out_col, got.product, got.last);
                return;
            end
            want = elements_due.pop_front();
            if (got !== want)
            begin
                bad_elements++;
                if (bad_elements <= 10)
                    $display({"element mismatch: expected row %0d col %0d product %h ",
                              "last %0b, got row %0d col %0d product %h last %0b"},
                             want.out_row, want.out_col, want.product, want.last,
                             got.out_row, got.out_col, got.product, got.last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_item_t cmd_item = '0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic result_valid;
    out_item_t result;

    product_tracker tracker;
    // entries loaded so far; unloaded entries must never be read
    bit a_set [DIM*DIM];
    bit b_set [DIM*DIM];
    // no gaps between items while set
    bit burst = 1'b0;
    // items accepted so far
    int items_sent = 0;

    matrix_multiply_engine dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd_item(cmd_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .result(result)
    );

    always #5 clk = ~clk;

    // collect streamed elements
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            tracker.match_element(result);
    end

    function automatic in_item_t make_item(input logic [1:0] cmd, input int r, input int c,
                                           input logic [VAL_W-1:0] v);
        in_item_t it;
        it.cmd = cmd;
        it.row = IDX_W'(r);
        it.col = IDX_W'(c);
        it.value = v;
        return it;
    endfunction

    // mix of full-range, small, mid-range and extreme Q16.16 values
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return VAL_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return VAL_W'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    // mostly small sizes, sometimes zero, full size or above it
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(9, 15));
            2: return CFG_DATA_W'(DIM);
            default: return CFG_DATA_W'($urandom_range(1, 4));
        endcase
    endfunction

    // present one item, wait for it to be taken, then an optional gap
    task automatic send(input in_item_t it);
        int gap;
        if (!start)
            start <= 1'b1;
        cmd_item <= it;
        do @(posedge clk); while (busy);
        tracker.take_item(it);
        items_sent++;
        if (it.cmd == CMD_WR_A)
            a_set[{it.row, it.col}] = 1'b1;
        if (it.cmd == CMD_WR_B)
            b_set[{it.row, it.col}] = 1'b1;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until the block is quiet and every element has arrived
    task automatic wait_idle();
        if (start)
            start <= 1'b0;
        do @(posedge clk); while (tracker.elements_due.size() != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] k,
                               input logic [CFG_DATA_W-1:0] c, input logic [FORM_W-1:0] f);
        wait_idle();
        put_reg(CFG_OUT_ROWS, r);
        put_reg(CFG_INNER_LEN, k);
        put_reg(CFG_OUT_COLS, c);
        put_reg(CFG_OPERAND_FORM, CFG_DATA_W'(f));
        cfg_we <= 1'b0;
    endtask

    // load every entry the next compute reads that has not been loaded yet
    task automatic fill_reads();
        int nr;
        int nk;
        int nc;
        bit need_a;
        bit need_b;
        nr = tracker.fit_dim(tracker.rows_reg);
        nk = tracker.fit_dim(tracker.inner_reg);
        nc = tracker.fit_dim(tracker.cols_reg);
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
            begin
                case (tracker.form_reg)
                    FORM_AB:
                    begin
                        need_a = r < nr && c < nk;
                        need_b = r < nk && c < nc;
                    end
                    FORM_ATB:
                    begin
                        need_a = r < nk && c < nr;
                        need_b = r < nk && c < nc;
                    end
                    FORM_ABT:
                    begin
                        need_a = r < nr && c < nk;
                        need_b = r < nc && c < nk;
                    end
                    default:
                    begin
                        need_a = r < nk && (c < nr || c < nc);
                        need_b = 1'b0;
                    end
                endcase
                if (need_a && !a_set[r*DIM+c])
                    send(make_item(CMD_WR_A, r, c, pick_value()));
                if (need_b && !b_set[r*DIM+c])
                    send(make_item(CMD_WR_B, r, c, pick_value()));
            end
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL matrix_multiply_engine");
        $finish;
    end

    // stimulus
    initial
    begin
        int batch;
        tracker = new;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1x1x1: overflow both ways, min times min, floor of a tiny negative
        load_config(4'd1, 4'd1, 4'd1, FORM_AB);
        send(make_item(CMD_WR_A, 0, 0, 32'h7FFF_FFFF));
        send(make_item(CMD_WR_B, 0, 0, 32'h7FFF_FFFF));
        send(make_item(CMD_COMPUTE, 0, 0, '0));
        send(make_item(CMD_WR_B, 0, 0, 32'h8000_0000));
        send(make_item(CMD_COMPUTE, 7, 7, '1));
        send(make_item(CMD_WR_A, 0, 0, 32'h8000_0000));
        send(make_item(CMD_COMPUTE, 0, 0, '0));
        send(make_item(CMD_WR_A, 0, 0, 32'hFFFF_FFFF));
        send(make_item(CMD_WR_B, 0, 0, 32'h0000_0001));
        send(make_item(CMD_COMPUTE, 0, 0, '0));
        // far corner entries and an unknown command
        send(make_item(CMD_WR_A, 7, 7, 32'h8000_0000));
        send(make_item(CMD_WR_B, 7, 7, 32'h7FFF_FFFF));
        send(make_item(CMD_NONE, 7, 7, 32'hFFFF_FFFF));
        // zero sizes behave as one; B unused
        load_config(4'd0, 4'd0, 4'd0, FORM_ATA);
        send(make_item(CMD_COMPUTE, 0, 0, '0));
        // transposed forms on 2x2
        load_config(4'd2, 4'd2, 4'd2, FORM_ATB);
        fill_reads();
        send(make_item(CMD_COMPUTE, 0, 0, '0));
        load_config(4'd2, 4'd2, 4'd2, FORM_ABT);
        send(make_item(CMD_COMPUTE, 0, 0, '0));

        // full output size with oversized row and column registers
        load_config(4'd15, 4'd2, 4'd12, FORM_W'($urandom_range(0, 3)));
        fill_reads();
        send(make_item(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));

        // random rounds: a few loads, maybe noise, then a compute
        while (items_sent < ITEM_TARGET)
        begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                load_config(pick_dim(), pick_dim(), pick_dim(), FORM_W'($urandom_range(0, 3)));
            batch = $urandom_range(0, 6);
            repeat (batch)
            begin
                send(make_item($urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A,
                               $urandom_range(0, 7), $urandom_range(0, 7), pick_value()));
            end
            if ($urandom_range(0, 4) == 0)
                send(make_item(CMD_NONE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
            fill_reads();
            send(make_item(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
        end

        wait_idle();
        if (tracker.bad_elements == 0 && tracker.elements_due.size() == 0)
            $display("PASS matrix_multiply_engine");
        else
            $display("FAIL matrix_multiply_engine");
        $finish;
    end

endmodule
